### hw/rtl/descriptor_free_list_allocator_macros.svh
// Assertion helpers shared by the allocator modules.
// Each expects i_clk and i_rst_n in the scope where it is used.
`ifndef DESCRIPTOR_FREE_LIST_ALLOCATOR_MACROS_SVH
`define DESCRIPTOR_FREE_LIST_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define DFLA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication
`define DFLA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

### hw/rtl/dfla_pkg.sv
package dfla_pkg;

    localparam int MAX_SLOTS   = 1024;
    localparam int FRAME_SLOTS = 3;

    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int F_W       = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int DEF_DEPTH = FRAME_SLOTS * MAX_SLOTS;
    localparam int DEF_AW    = $clog2(DEF_DEPTH);
    localparam int BIT_W     = $clog2(IDX_W + 1);

    // fixed field widths
    localparam int ADDR_W    = 64;
    localparam int CMD_W     = 2;
    localparam int FRM_W     = 2;
    localparam int ST_W      = 3;
    localparam int SLOT_W    = 10;
    localparam int RET_W     = 11;
    localparam int CAP_W     = 11;
    localparam int SIZE_W    = 11;
    localparam int CFG_IDX_W = 3;
    localparam int LIM_W     = CNT_W + SIZE_W;
    localparam int OFF_W     = IDX_W + SIZE_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHADER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PBASE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SBASE     = 3'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_PROC  = 2'd2,
        CMD_INIT  = 2'd3
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        STS_OK         = 3'd0,
        STS_FULL       = 3'd1,
        STS_BAD_ADDR   = 3'd2,
        STS_NONE_ALLOC = 3'd3,
        STS_NULL       = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ALLOC_ADD,
        ST_FREE_CMP,
        ST_FREE_DIV,
        ST_FREE_END,
        ST_PROC_RD,
        ST_PROC_WR,
        ST_PROC_END,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic    latch;
        logic    alloc_mul;
        logic    alloc_add;
        logic    free_prep;
        logic    div_init;
        logic    div_step;
        logic    free_commit;
        logic    proc_start;
        logic    proc_wr;
        logic    proc_end;
        logic    rebuild;
        logic    res_we;
        t_status res_status;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic addr_zero;
        logic cnt_zero;
        logic addr_bad;
        logic alloc_full;
        logic diff_ge_lim;
        logic div_last;
        logic rem_zero;
        logic dlist_full;
        logic proc_done;
        logic out_busy;
    } t_dp_sts;

endpackage

### hw/rtl/dfla_req_if.sv
interface dfla_req_if import dfla_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] handle_address;
    logic [FRM_W-1:0]  frame_slot;

    modport source (output valid, command, handle_address, frame_slot, input ready);
    modport sink   (input valid, command, handle_address, frame_slot, output ready);
endinterface

### hw/rtl/dfla_rsp_if.sv
interface dfla_rsp_if import dfla_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot_index;
    logic [ADDR_W-1:0] primary_handle;
    logic [ADDR_W-1:0] secondary_handle;
    logic [RET_W-1:0]  returned_count;

    modport source (output valid, status, slot_index, primary_handle, secondary_handle,
                    returned_count, input ready);
    modport sink   (input valid, status, slot_index, primary_handle, secondary_handle,
                    returned_count, output ready);
endinterface

### hw/rtl/dfla_dpath.sv
`include "descriptor_free_list_allocator_macros.svh"

module dfla_dpath import dfla_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [ADDR_W-1:0]    i_handle_address,
    input  logic [FRM_W-1:0]     i_frame_slot,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [ST_W-1:0]      o_status,
    output logic [SLOT_W-1:0]    o_slot_index,
    output logic [ADDR_W-1:0]    o_primary_handle,
    output logic [ADDR_W-1:0]    o_secondary_handle,
    output logic [RET_W-1:0]     o_returned_count
);

    // configuration
    logic [CAP_W-1:0]  r_capacity;
    logic              r_shader_vis;
    logic [SIZE_W-1:0] r_slot_size;
    logic [ADDR_W-1:0] r_pbase;
    logic [ADDR_W-1:0] r_sbase;

    // latched item
    t_cmd              r_cmd;
    logic [ADDR_W-1:0] r_addr;
    logic [F_W-1:0]    r_frame;

    // allocator state
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_hwm;
    logic [CNT_W-1:0]  r_dcnt [FRAME_SLOTS];
    logic [CNT_W-1:0]  r_k;

    // memories and read registers
    logic [IDX_W-1:0]  m_stack [MAX_SLOTS];
    logic [IDX_W-1:0]  m_def   [DEF_DEPTH];
    logic [IDX_W-1:0]  r_stk_q;
    logic [IDX_W-1:0]  r_def_q;

    // arithmetic
    logic [IDX_W-1:0]  r_idx;
    logic [OFF_W-1:0]  r_off;
    logic [ADDR_W-1:0] r_diff;
    logic [LIM_W-1:0]  r_lim;
    logic [LIM_W-1:0]  r_rem;
    logic [IDX_W-1:0]  r_q;
    logic [BIT_W-1:0]  r_bit;

    // pending result and output register
    t_status           r_res_status;
    logic [IDX_W-1:0]  r_res_idx;
    logic [ADDR_W-1:0] r_res_prim;
    logic [ADDR_W-1:0] r_res_sec;
    logic [CNT_W-1:0]  r_res_ret;
    logic              r_out_valid;

    logic [CNT_W-1:0]  w_eff_cap;
    logic [F_W-1:0]    w_frame_in;
    logic [IDX_W-1:0]  w_alloc_idx;
    logic [LIM_W-1:0]  w_dsor;
    logic              w_ge;
    logic [CNT_W-1:0]  w_dcnt_f;
    logic [DEF_AW-1:0] w_def_base;
    logic [DEF_AW-1:0] w_def_waddr;
    logic [DEF_AW-1:0] w_def_raddr;

    assign w_eff_cap  = (32'(r_capacity) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(r_capacity);
    assign w_frame_in = (32'(i_frame_slot) >= FRAME_SLOTS) ? F_W'(FRAME_SLOTS - 1)
                                                            : F_W'(i_frame_slot);
    // entries at or above the high-water mark were never written: identity
    assign w_alloc_idx = (r_count < r_hwm) ? r_stk_q : r_count[IDX_W-1:0];
    assign w_dsor      = LIM_W'(r_slot_size) << r_bit;
    assign w_ge        = (r_rem >= w_dsor);
    assign w_dcnt_f    = r_dcnt[r_frame];
    assign w_def_base  = DEF_AW'(DEF_AW'(r_frame) * DEF_AW'(MAX_SLOTS));
    assign w_def_waddr = DEF_AW'(w_def_base + DEF_AW'(w_dcnt_f[IDX_W-1:0]));
    assign w_def_raddr = DEF_AW'(w_def_base + DEF_AW'(r_k[IDX_W-1:0]));

    // status to the controller
    always_comb begin
        o_sts.cmd         = r_cmd;
        o_sts.addr_zero   = (r_addr == '0);
        o_sts.cnt_zero    = (r_count == '0);
        o_sts.addr_bad    = (r_addr < r_pbase) || (r_slot_size == '0);
        o_sts.alloc_full  = (r_count >= w_eff_cap);
        o_sts.diff_ge_lim = (r_diff >= ADDR_W'(r_lim));
        o_sts.div_last    = (r_bit == '0);
        o_sts.rem_zero    = (r_rem == '0);
        o_sts.dlist_full  = (32'(w_dcnt_f) >= MAX_SLOTS);
        o_sts.proc_done   = (r_k == w_dcnt_f) || (r_count == '0);
        o_sts.out_busy    = r_out_valid && !i_out_ready;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= CAP_W'(1024);
            r_shader_vis <= 1'b0;
            r_slot_size  <= SIZE_W'(32);
            r_pbase      <= '0;
            r_sbase      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CAPACITY:  r_capacity   <= i_cfg_data[CAP_W-1:0];
                CFG_SHADER:    r_shader_vis <= i_cfg_data[0];
                CFG_SLOT_SIZE: r_slot_size  <= i_cfg_data[SIZE_W-1:0];
                CFG_PBASE:     r_pbase      <= i_cfg_data;
                CFG_SBASE:     r_sbase      <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.rebuild) begin
            r_count <= '0;
            r_hwm   <= '0;
            for (int i = 0; i < FRAME_SLOTS; i++) begin
                r_dcnt[i] <= '0;
            end
        end else begin
            if (i_cmd.alloc_mul) begin
                r_count <= r_count + 1'b1;
                if (r_count == r_hwm) begin
                    r_hwm <= r_count + 1'b1;
                end
            end
            if (i_cmd.proc_wr) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.free_commit && !o_sts.dlist_full) begin
                r_dcnt[r_frame] <= w_dcnt_f + 1'b1;
            end
            if (i_cmd.proc_end) begin
                r_dcnt[r_frame] <= '0;
            end
        end
    end

    // free stack
    always_ff @(posedge i_clk) begin
        r_stk_q <= m_stack[r_count[IDX_W-1:0]];
        if (i_cmd.proc_wr) begin
            m_stack[IDX_W'(r_count - 1'b1)] <= r_def_q;
        end
    end

    // deferred lists
    always_ff @(posedge i_clk) begin
        r_def_q <= m_def[w_def_raddr];
        if (i_cmd.free_commit && !o_sts.dlist_full) begin
            m_def[w_def_waddr] <= r_q;
        end
    end

    // item latch, address math, divider, drain counter, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd        <= t_cmd'(i_command);
            r_addr       <= i_handle_address;
            r_frame      <= w_frame_in;
            r_res_status <= STS_OK;
            r_res_idx    <= '0;
            r_res_prim   <= '0;
            r_res_sec    <= '0;
            r_res_ret    <= '0;
        end
        if (i_cmd.alloc_mul) begin
            r_idx <= w_alloc_idx;
            r_off <= OFF_W'(w_alloc_idx) * OFF_W'(r_slot_size);
        end
        if (i_cmd.alloc_add) begin
            r_res_idx  <= r_idx;
            r_res_prim <= r_pbase + ADDR_W'(r_off);
            r_res_sec  <= r_shader_vis ? (r_sbase + ADDR_W'(r_off)) : '0;
        end
        if (i_cmd.free_prep) begin
            r_diff <= r_addr - r_pbase;
            r_lim  <= LIM_W'(w_eff_cap) * LIM_W'(r_slot_size);
        end
        // restoring division, one quotient bit a cycle
        if (i_cmd.div_init) begin
            r_rem <= r_diff[LIM_W-1:0];
            r_q   <= '0;
            r_bit <= BIT_W'(IDX_W - 1);
        end
        if (i_cmd.div_step) begin
            if (w_ge) begin
                r_rem <= r_rem - w_dsor;
            end
            r_q   <= IDX_W'({r_q, w_ge});
            r_bit <= r_bit - 1'b1;
        end
        if (i_cmd.free_commit) begin
            r_res_idx <= r_q;
        end
        if (i_cmd.proc_start) begin
            r_k <= '0;
        end
        if (i_cmd.proc_wr) begin
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.proc_end) begin
            r_res_ret <= r_k;
        end
        if (i_cmd.res_we) begin
            r_res_status <= i_cmd.res_status;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status           <= r_res_status;
            o_slot_index       <= SLOT_W'(r_res_idx);
            o_primary_handle   <= r_res_prim;
            o_secondary_handle <= r_res_sec;
            o_returned_count   <= RET_W'(r_res_ret);
        end
    end

    assign o_out_valid = r_out_valid;

    `DFLA_ASSERT_IMP(a_cnt_below_hwm, 1'b1, r_count <= r_hwm)
    `DFLA_ASSERT_IMP(a_cnt_in_range, 1'b1, 32'(r_count) <= MAX_SLOTS)
    `DFLA_ASSERT_NXT(a_drain_pops, i_cmd.proc_wr, r_count == CNT_W'($past(r_count) - 1'b1))

endmodule

### hw/rtl/dfla_ctrl.sv
`include "descriptor_free_list_allocator_macros.svh"

module dfla_ctrl import dfla_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.res_status = STS_OK;
        o_in_ready       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (i_sts.cmd)
                    CMD_ALLOC: begin
                        if (i_sts.alloc_full) begin
                            o_cmd.res_we     = 1'b1;
                            o_cmd.res_status = STS_FULL;
                            n_state          = ST_FINISH;
                        end else begin
                            o_cmd.alloc_mul = 1'b1;
                            n_state         = ST_ALLOC_ADD;
                        end
                    end
                    CMD_FREE: begin
                        priority if (i_sts.addr_zero) begin
                            o_cmd.res_we     = 1'b1;
                            o_cmd.res_status = STS_NULL;
                            n_state          = ST_FINISH;
                        end else if (i_sts.cnt_zero) begin
                            o_cmd.res_we     = 1'b1;
                            o_cmd.res_status = STS_NONE_ALLOC;
                            n_state          = ST_FINISH;
                        end else if (i_sts.addr_bad) begin
                            o_cmd.res_we     = 1'b1;
                            o_cmd.res_status = STS_BAD_ADDR;
                            n_state          = ST_FINISH;
                        end else begin
                            o_cmd.free_prep = 1'b1;
                            n_state         = ST_FREE_CMP;
                        end
                    end
                    CMD_PROC: begin
                        o_cmd.proc_start = 1'b1;
                        n_state          = ST_PROC_RD;
                    end
                    CMD_INIT: begin
                        o_cmd.rebuild = 1'b1;
                        n_state       = ST_FINISH;
                    end
                    default: n_state = ST_FINISH;
                endcase
            end
            ST_ALLOC_ADD: begin
                o_cmd.alloc_add = 1'b1;
                n_state         = ST_FINISH;
            end
            ST_FREE_CMP: begin
                if (i_sts.diff_ge_lim) begin
                    o_cmd.res_we     = 1'b1;
                    o_cmd.res_status = STS_BAD_ADDR;
                    n_state          = ST_FINISH;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = ST_FREE_DIV;
                end
            end
            ST_FREE_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_FREE_END;
                end
            end
            ST_FREE_END: begin
                o_cmd.res_we = 1'b1;
                n_state      = ST_FINISH;
                if (!i_sts.rem_zero) begin
                    o_cmd.res_status = STS_BAD_ADDR;
                end else begin
                    o_cmd.free_commit = 1'b1;
                    o_cmd.res_status  = i_sts.dlist_full ? STS_FULL : STS_OK;
                end
            end
            ST_PROC_RD: begin
                n_state = i_sts.proc_done ? ST_PROC_END : ST_PROC_WR;
            end
            ST_PROC_WR: begin
                o_cmd.proc_wr = 1'b1;
                n_state       = ST_PROC_RD;
            end
            ST_PROC_END: begin
                o_cmd.proc_end = 1'b1;
                n_state        = ST_FINISH;
            end
            ST_FINISH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `DFLA_ASSERT_NXT(a_accept_dispatch, i_in_valid && o_in_ready, r_state == ST_DISPATCH)
    `DFLA_ASSERT_NXT(a_div_to_end, r_state == ST_FREE_DIV && i_sts.div_last,
                     r_state == ST_FREE_END)
    `DFLA_ASSERT_NXT(a_finish_load, r_state == ST_FINISH && !i_sts.out_busy,
                     r_state == ST_IDLE)

endmodule

### hw/rtl/descriptor_free_list_allocator.sv
// Descriptor free-list allocator.
// Request channel i_req carries command, handle_address and frame_slot; one
// response per request leaves on o_rsp with status, slot_index, both handles
// and returned_count. The user must write registers through i_cfg_we /
// i_cfg_idx / i_cfg_data only while the block is idle; it is not enforced.
// One request is in flight at a time. States after DISPATCH, before FINISH:
//   allocate        ALLOC_ADD, or none when the heap is full
//   free            none on an early reject (null, nothing allocated, below
//                   base, zero stride), FREE_CMP if index is past capacity,
//                   else FREE_CMP, FREE_DIV (one quotient bit per cycle, 10
//                   bits), FREE_END
//   process frame   PROC_RD, PROC_WR per returned index (deferred list read,
//                   then stack write), PROC_END; initialize: none
// A new request is accepted in the cycle after the previous one is handed to
// the response register, so it may overlap a response still waiting for ready.
// If the receiver stalls, the response register holds and the finished item
// waits in place until the register frees.
// Reset (synchronous, active low) restores register defaults and empties the
// free stack and every deferred list at once; no clearing pass is needed.
module descriptor_free_list_allocator import dfla_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dfla_req_if.sink             i_req,
    dfla_rsp_if.source           o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    assign i_req.ready = w_in_ready;

    dfla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    dfla_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_command          (i_req.command),
        .i_handle_address   (i_req.handle_address),
        .i_frame_slot       (i_req.frame_slot),
        .i_out_ready        (o_rsp.ready),
        .o_out_valid        (o_rsp.valid),
        .o_status           (o_rsp.status),
        .o_slot_index       (o_rsp.slot_index),
        .o_primary_handle   (o_rsp.primary_handle),
        .o_secondary_handle (o_rsp.secondary_handle),
        .o_returned_count   (o_rsp.returned_count)
    );

endmodule

### tb/dfla_alloc_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port, tracks the allocator state and
// compares every response transaction with the oldest predicted one.
module dfla_alloc_checker import dfla_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dfla_req_if                  req,
    dfla_rsp_if                  rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);

    typedef struct {
        t_status           status;
        logic [SLOT_W-1:0] slot_index;
        logic [ADDR_W-1:0] primary_handle;
        logic [ADDR_W-1:0] secondary_handle;
        logic [RET_W-1:0]  returned_count;
    } t_alloc_rsp;

    // shadow registers
    logic [CAP_W-1:0]  capacity_r;
    logic              shader_r;
    logic [SIZE_W-1:0] slot_size_r;
    logic [ADDR_W-1:0] pbase_r;
    logic [ADDR_W-1:0] sbase_r;

    // shadow allocator state
    logic [SLOT_W-1:0] free_slots [MAX_SLOTS];
    int                live_count;
    logic [SLOT_W-1:0] pending_frees [FRAME_SLOTS][MAX_SLOTS];
    int                pending_cnt [FRAME_SLOTS];

    t_alloc_rsp rsp_due_q [$];
    int         mismatches;
    int         pending_n = 0;

    assign o_errors  = mismatches;
    assign o_pending = pending_n;

    task automatic rebuild_heap();
        for (int i = 0; i < MAX_SLOTS; i++) free_slots[i] = SLOT_W'(i);
        live_count = 0;
        for (int f = 0; f < FRAME_SLOTS; f++) pending_cnt[f] = 0;
    endtask

    // compute the response for one request and update the shadow state
    task automatic apply_request(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                                 input logic [FRM_W-1:0] frm, output t_alloc_rsp r);
        int                eff;
        int                f;
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] diff;
        logic [ADDR_W-1:0] quot;
        r = '{STS_OK, '0, '0, '0, '0};
        eff = (capacity_r > MAX_SLOTS) ? MAX_SLOTS : int'(capacity_r);
        f = (frm >= FRAME_SLOTS) ? FRAME_SLOTS - 1 : int'(frm);
        case (t_cmd'(cmd))
            CMD_ALLOC: begin
                if (live_count >= eff) begin
                    r.status = STS_FULL;
                end else begin
                    r.slot_index = free_slots[live_count % MAX_SLOTS];
                    off = ADDR_W'(r.slot_index) * ADDR_W'(slot_size_r);
                    live_count++;
                    r.primary_handle = pbase_r + off;
                    r.secondary_handle = shader_r ? sbase_r + off : '0;
                end
            end
            CMD_FREE: begin
                if (addr == 0) begin
                    r.status = STS_NULL;
                end else if (live_count == 0) begin
                    r.status = STS_NONE_ALLOC;
                end else if (addr < pbase_r || slot_size_r == 0) begin
                    r.status = STS_BAD_ADDR;
                end else begin
                    diff = addr - pbase_r;
                    quot = diff / ADDR_W'(slot_size_r);
                    if (diff % ADDR_W'(slot_size_r) != 0 || quot >= ADDR_W'(eff)) begin
                        r.status = STS_BAD_ADDR;
                    end else begin
                        r.slot_index = quot[SLOT_W-1:0];
                        if (pending_cnt[f] >= MAX_SLOTS) begin
                            r.status = STS_FULL;
                        end else begin
                            pending_frees[f][pending_cnt[f]] = quot[SLOT_W-1:0];
                            pending_cnt[f]++;
                        end
                    end
                end
            end
            CMD_PROC: begin
                // give back while something is allocated, drop the rest
                for (int k = 0; k < pending_cnt[f]; k++) begin
                    if (live_count == 0) break;
                    live_count--;
                    free_slots[live_count % MAX_SLOTS] = pending_frees[f][k];
                    r.returned_count++;
                end
                pending_cnt[f] = 0;
            end
            default: rebuild_heap();
        endcase
    endtask

    always @(posedge i_clk) begin
        t_alloc_rsp got;
        t_alloc_rsp want;
        if (!i_rst_n) begin
            capacity_r  = 11'd1024;
            shader_r    = 1'b0;
            slot_size_r = 11'd32;
            pbase_r     = '0;
            sbase_r     = '0;
            rebuild_heap();
            rsp_due_q.delete();
            mismatches = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CAPACITY:  capacity_r  = i_cfg_data[CAP_W-1:0];
                    CFG_SHADER:    shader_r    = i_cfg_data[0];
                    CFG_SLOT_SIZE: slot_size_r = i_cfg_data[SIZE_W-1:0];
                    CFG_PBASE:     pbase_r     = i_cfg_data;
                    CFG_SBASE:     sbase_r     = i_cfg_data;
                    default: ;
                endcase
            end
            if (req.valid && req.ready) begin
                apply_request(req.command, req.handle_address, req.frame_slot, want);
                rsp_due_q = {rsp_due_q, want};
            end
            if (rsp.valid && rsp.ready) begin
                got = '{t_status'(rsp.status), rsp.slot_index, rsp.primary_handle,
                        rsp.secondary_handle, rsp.returned_count};
                if (rsp_due_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: response with nothing outstanding: st=%0d idx=%0d",
                                 $realtime, got.status, got.slot_index);
                end else begin
                    want = rsp_due_q.pop_front();
                    if (got.status !== want.status || got.slot_index !== want.slot_index ||
                        got.primary_handle !== want.primary_handle ||
                        got.secondary_handle !== want.secondary_handle ||
                        got.returned_count !== want.returned_count) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("%0t: mismatch exp st=%0d idx=%0d p=%h s=%h ret=%0d",
                                   $realtime, want.status, want.slot_index,
                                   want.primary_handle, want.secondary_handle,
                                   want.returned_count);
                            $display(" | got st=%0d idx=%0d p=%h s=%h ret=%0d",
                                     got.status, got.slot_index, got.primary_handle,
                                     got.secondary_handle, got.returned_count);
                        end
                    end
                end
            end
        end
        pending_n = rsp_due_q.size();
    end

endmodule

### tb/tb_descriptor_free_list_allocator.sv
`timescale 1ns / 1ps

module tb_descriptor_free_list_allocator;
    import dfla_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD   = 3000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [ADDR_W-1:0]    cfg_data;
    int   err_count;
    int   outstanding;
    int   quiet_cycles = 0;
    bit   no_idle;
    bit   long_hold;

    // host-side copy of the registers for building addresses
    logic [CAP_W-1:0]  cur_cap;
    logic [SIZE_W-1:0] cur_size;
    logic [ADDR_W-1:0] cur_pbase;

    dfla_req_if req_if ();
    dfla_rsp_if rsp_if ();

    descriptor_free_list_allocator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    dfla_alloc_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .req        (req_if),
        .rsp        (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (err_count),
        .o_pending  (outstanding)
    );

    always #1 i_clk = ~i_clk;

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // response side: random stall bursts, one long hold on request
    initial begin
        bit hold_taken;
        hold_taken = 1'b0;
        rsp_if.ready <= 1'b0;
        forever begin
            if (long_hold && !hold_taken) begin
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_taken = 1'b1;
            end else if (!no_idle && $urandom_range(0, 2) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                rsp_if.ready <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
        end
    end

    task automatic send_req(input t_cmd c, input logic [ADDR_W-1:0] a,
                            input logic [FRM_W-1:0] fs);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.command        <= c;
        req_if.handle_address <= a;
        req_if.frame_slot     <= fs;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // wait until every response is back; the block is then idle
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [CAP_W-1:0] cap, input logic shader,
                                input logic [SIZE_W-1:0] sz, input logic [ADDR_W-1:0] pb,
                                input logic [ADDR_W-1:0] sb);
        logic [ADDR_W-1:0] vals [5];
        vals = '{ADDR_W'(cap), ADDR_W'(shader), ADDR_W'(sz), pb, sb};
        for (int i = 0; i < 5; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_IDX_W'(i);
            cfg_data <= vals[i];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        cur_cap   = cap;
        cur_size  = sz;
        cur_pbase = pb;
    endtask

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // free address: mostly a legal slot, else the various bad shapes
    function automatic logic [ADDR_W-1:0] pick_free_addr();
        int eff;
        int r;
        eff = (cur_cap > MAX_SLOTS) ? MAX_SLOTS : int'(cur_cap);
        r = $urandom_range(0, 99);
        if (r < 70)
            return cur_pbase + ADDR_W'($urandom_range(0, eff - 1)) * ADDR_W'(cur_size);
        if (r < 80)
            return cur_pbase + ADDR_W'($urandom_range(0, eff - 1)) * ADDR_W'(cur_size)
                   + ADDR_W'($urandom_range(1, 7));
        if (r < 88)
            return cur_pbase + ADDR_W'($urandom_range(eff, MAX_SLOTS + 4)) * ADDR_W'(cur_size);
        if (r < 93)
            return cur_pbase - ADDR_W'($urandom_range(1, 64));
        if (r < 97)
            return '0;
        return rand64();
    endfunction

    task automatic random_config();
        logic [CAP_W-1:0]  cap;
        logic [SIZE_W-1:0] sz;
        case ($urandom_range(0, 4))
            0: cap = 11'd1;
            1: cap = 11'd2;
            2: cap = CAP_W'($urandom_range(3, 40));
            3: cap = 11'd1024;
            default: cap = CAP_W'($urandom_range(1025, 2047));
        endcase
        case ($urandom_range(0, 9))
            0: sz = 11'd0;
            1: sz = 11'd1;
            2: sz = 11'd1024;
            3: sz = 11'd2047;
            default: sz = SIZE_W'($urandom_range(1, 1024));
        endcase
        program_regs(cap, 1'($urandom), sz,
                     ($urandom_range(0, 1) != 0) ? rand64() : ADDR_W'($urandom_range(0, 4096)),
                     rand64());
    endtask

    task automatic random_items(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40)      send_req(CMD_ALLOC, rand64(), 2'($urandom));
            else if (r < 78) send_req(CMD_FREE, pick_free_addr(), 2'($urandom));
            else if (r < 97) send_req(CMD_PROC, rand64(), 2'($urandom));
            else             send_req(CMD_INIT, rand64(), 2'($urandom));
        end
    endtask

    initial begin
        i_rst_n               <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_idx               <= '0;
        cfg_data              <= '0;
        req_if.valid          <= 1'b0;
        req_if.command        <= CMD_ALLOC;
        req_if.handle_address <= '0;
        req_if.frame_slot     <= '0;
        no_idle   = 1'b0;
        long_hold = 1'b0;
        cur_cap   = 11'd1024;
        cur_size  = 11'd32;
        cur_pbase = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, register defaults
        send_req(CMD_FREE, 64'd32, 2'd0);          // nothing allocated
        send_req(CMD_FREE, 64'd0, 2'd0);           // null handle
        send_req(CMD_ALLOC, '0, 2'd0);
        send_req(CMD_ALLOC, '0, 2'd0);
        send_req(CMD_ALLOC, '0, 2'd0);
        send_req(CMD_FREE, 64'd33, 2'd0);          // misaligned
        send_req(CMD_FREE, 64'd32 * 1024, 2'd0);   // index past capacity
        send_req(CMD_FREE, 64'd32, 2'd3);          // frame slot saturates
        send_req(CMD_FREE, 64'd64, 2'd0);
        send_req(CMD_PROC, '0, 2'd3);
        send_req(CMD_PROC, '0, 2'd0);
        send_req(CMD_ALLOC, '0, 2'd0);
        send_req(CMD_INIT, '1, 2'd3);
        send_req(CMD_ALLOC, '1, 2'd1);
        drain();

        // extremes: single slot, top of address space, wrap on add
        program_regs(11'd1, 1'b1, 11'd1024, 64'hFFFF_FFFF_FFFF_FC00, '1);
        send_req(CMD_ALLOC, '0, 2'd0);
        send_req(CMD_ALLOC, '0, 2'd0);             // heap full
        send_req(CMD_FREE, 64'd5, 2'd1);           // below base
        send_req(CMD_FREE, '1, 2'd1);              // misaligned
        send_req(CMD_FREE, 64'hFFFF_FFFF_FFFF_FC00, 2'd2);
        send_req(CMD_PROC, '0, 2'd2);
        drain();
        program_regs(11'd2047, 1'b1, 11'd1024, 64'hFFFF_FFFF_FFFF_FC00, 64'hFFFF_FFFF_FFFF_FFFF);
        send_req(CMD_ALLOC, '0, 2'd0);
        send_req(CMD_ALLOC, '0, 2'd0);             // address wraps
        send_req(CMD_FREE, 64'd0 + 64'd0 + 64'h1, 2'd0);
        drain();
        program_regs(11'd8, 1'b0, 11'd0, 64'd16, '0);
        send_req(CMD_FREE, 64'd16, 2'd0);          // zero stride
        send_req(CMD_INIT, '0, 2'd0);
        drain();

        // overfill one deferred list, then drain it with only one slot live
        program_regs(11'd4, 1'b1, 11'd1, 64'd1000, 64'h8000_0000_0000_0000);
        send_req(CMD_ALLOC, '0, 2'd1);
        for (int i = 0; i < MAX_SLOTS + 2; i++) send_req(CMD_FREE, 64'd1000, 2'd1);
        send_req(CMD_PROC, '0, 2'd1);
        send_req(CMD_PROC, '0, 2'd2);
        drain();

        // random phases
        for (int p = 0; p < 4; p++) begin
            random_config();
            if (p == 3) no_idle = 1'b1;
            if (p == 2) begin
                random_items(5);
                long_hold = 1'b1;
                random_items(20);
            end else begin
                random_items(25);
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (err_count == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
